// ===== src/cos_pkg.sv =====
package cos_pkg;

	// Fixed field widths of the item and result ports
	localparam int FUNC_W  = 1;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// Operation codes carried by func
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

	// Command from the sequencer to the pointer unit
	typedef struct packed {
		logic push;
		logic pop;
	} ptr_cmd_t;

	// Status of the pointer unit towards the sequencer
	typedef struct packed {
		logic empty;
		logic full;
	} ptr_flags_t;

endpackage

// ===== src/cos_ram.sv =====
module cos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/cos_ptr.sv =====
module cos_ptr
	import cos_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ptr_cmd_t                   cmd,
	output logic [$clog2(DEPTH)-1:0]   top_idx,
	output logic [$clog2(DEPTH)-1:0]   push_idx,
	output logic [$clog2(DEPTH+1)-1:0] held,
	output ptr_flags_t                 flags
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [IDX_W-1:0] top_q;
	logic [CNT_W-1:0] held_q;
	logic [IDX_W-1:0] idx_up;
	logic [IDX_W-1:0] idx_down;

	// Wrap the circular index in both directions
	assign idx_up   = (top_q == IDX_LAST) ? '0 : top_q + 1'b1;
	assign idx_down = (top_q == '0) ? IDX_LAST : top_q - 1'b1;

	assign flags.empty = (held_q == '0);
	assign flags.full  = (held_q == CNT_FULL);

	// Advance on push, step back on pop; the count saturates when full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= IDX_LAST;
			held_q <= '0;
		end else if (cmd.push) begin
			top_q <= idx_up;
			if (!flags.full) begin
				held_q <= held_q + 1'b1;
			end
		end else if (cmd.pop && !flags.empty) begin
			top_q  <= idx_down;
			held_q <= held_q - 1'b1;
		end
	end

	assign top_idx  = top_q;
	assign push_idx = idx_up;
	assign held     = held_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_FULL)
		else $error("entry count above depth");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && flags.full |=> held_q == CNT_FULL)
		else $error("push on full stack changed the count");

	a_pop_unwinds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && !flags.empty && !cmd.push |=>
			held_q == $past(held_q) - 1'b1 && top_q == $past(idx_down))
		else $error("pop did not step back index and count");

endmodule

// ===== src/circular_overwrite_stack.sv =====
// Channel   Valid          Ready          Payload
// item      item_valid     item_ready     func, push_value
// result    result_valid   result_ready   popped_value, pop_valid, overwrote_oldest,
//                                          entry_count
//
// A push, or a pop on an empty stack, has its result registered at the accepting edge.
// A pop that finds an entry passes through ST_READ: the entry memory registers the
// read data, and the result register then takes it. One item is in flight at a time.
// Reset puts the index on the last entry and clears the count at once; the entry
// memory is not cleared.
// A result waiting in the output register does not block the next item if it is
// taken in the same cycle.
module circular_overwrite_stack
	import cos_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [FUNC_W-1:0]         func,
	input  logic signed [VALUE_W-1:0] push_value,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic signed [VALUE_W-1:0] popped_value,
	output logic                      pop_valid,
	output logic                      overwrote_oldest,
	output logic [COUNT_W-1:0]        entry_count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	logic [VALUE_W-1:0] popped_q;
	logic              pop_valid_q;
	logic              overwrote_q;
	logic [CNT_W-1:0]  count_q;

	logic              accept;
	logic              is_push;
	ptr_cmd_t          cmd;
	ptr_flags_t        flags;
	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  push_idx;
	logic [CNT_W-1:0]  held;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [DATA_WIDTH-1:0] wr_data;

	// Take an item when idle and the output register is free or draining
	assign item_ready = (state_q == ST_IDLE) && (!out_valid_q || result_ready);
	assign accept     = item_valid && item_ready;
	assign is_push    = (func == FUNC_PUSH);
	assign cmd.push   = accept && is_push;
	assign cmd.pop    = accept && (func == FUNC_POP);
	assign wr_data    = DATA_WIDTH'($unsigned(push_value));

	cos_ptr #(
		.DEPTH(DEPTH)
	) u_ptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.top_idx (top_idx),
		.push_idx(push_idx),
		.held    (held),
		.flags   (flags)
	);

	cos_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(push_idx),
		.wdata(wr_data),
		.re   (cmd.pop && !flags.empty),
		.raddr(top_idx),
		.rdata(rd_data)
	);

	// Sequence items and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			popped_q    <= '0;
			pop_valid_q <= 1'b0;
			overwrote_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_push) begin
							out_valid_q <= 1'b1;
							popped_q    <= '0;
							pop_valid_q <= 1'b0;
							overwrote_q <= flags.full;
							count_q     <= flags.full ? held : held + 1'b1;
						end else if (flags.empty) begin
							out_valid_q <= 1'b1;
							popped_q    <= '0;
							pop_valid_q <= 1'b0;
							overwrote_q <= 1'b0;
							count_q     <= '0;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// Read data is back; the pointer unit already holds the new count
					out_valid_q <= 1'b1;
					popped_q    <= VALUE_W'(rd_data);
					pop_valid_q <= 1'b1;
					overwrote_q <= 1'b0;
					count_q     <= held;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid     = out_valid_q;
	assign popped_value     = popped_q;
	assign pop_valid        = pop_valid_q;
	assign overwrote_oldest = overwrote_q;
	assign entry_count      = COUNT_W'(count_q);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(pop_valid_q && overwrote_q))
		else $error("result flags pop and overwrite both set");

	a_read_completes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> out_valid_q && pop_valid_q && state_q == ST_IDLE)
		else $error("memory read did not produce a result");

	a_out_free_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("pending result would be overwritten by read data");

endmodule

// ===== tb/tb_circular_overwrite_stack.sv =====
`timescale 1ns / 100ps

module tb_circular_overwrite_stack;
	import cos_pkg::*;

	localparam int STACK_DEPTH    = 16;
	localparam int RX_HOLD_CYCLES = 80;
	localparam int STALL_LIMIT    = 2000;
	localparam int ITEMS_PER_PHASE = 400;

	typedef struct {
		logic [FUNC_W-1:0]         op;
		logic signed [VALUE_W-1:0] value;
	} stack_item_t;

	typedef struct {
		logic signed [VALUE_W-1:0] popped;
		logic                      valid;
		logic                      overwrote;
		logic [COUNT_W-1:0]        count;
	} stack_result_t;

	logic                      clk              = 1'b0;
	logic                      arst_n           = 1'b0;
	logic                      item_valid       = 1'b0;
	logic                      item_ready;
	logic [FUNC_W-1:0]         func             = FUNC_PUSH;
	logic signed [VALUE_W-1:0] push_value       = '0;
	logic                      result_valid;
	logic                      result_ready     = 1'b0;
	logic signed [VALUE_W-1:0] popped_value;
	logic                      pop_valid;
	logic                      overwrote_oldest;
	logic [COUNT_W-1:0]        entry_count;

	circular_overwrite_stack dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.func             (func),
		.push_value       (push_value),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.popped_value     (popped_value),
		.pop_valid        (pop_valid),
		.overwrote_oldest (overwrote_oldest),
		.entry_count      (entry_count)
	);

	always #5 clk = ~clk;

	// Items waiting to be offered, and results owed by the block
	stack_item_t   pending_ops[$];
	stack_result_t awaited_results[$];
	stack_item_t   next_op;
	stack_item_t   seen_op;
	stack_result_t want_result;

	// Shadow copy of the stack
	logic signed [VALUE_W-1:0] shadow_mem[STACK_DEPTH];
	int shadow_top  = STACK_DEPTH - 1;
	int shadow_fill = 0;

	int  tx_idle_pct   = 0;
	int  rx_idle_pct   = 0;
	int  hold_requests = 0;
	int  holds_served  = 0;
	int  rx_hold_left  = 0;
	int  stall_cycles  = 0;
	int  mismatches    = 0;
	bit  item_fire     = 1'b0;

	// Apply one operation to the shadow stack and give the result it owes
	function automatic stack_result_t stack_apply(input stack_item_t it);
		stack_result_t r;
		r.popped    = '0;
		r.valid     = 1'b0;
		r.overwrote = 1'b0;
		if (it.op == FUNC_PUSH) begin
			shadow_top = (shadow_top == STACK_DEPTH - 1) ? 0 : shadow_top + 1;
			shadow_mem[shadow_top] = it.value;
			if (shadow_fill == STACK_DEPTH)
				r.overwrote = 1'b1;
			else
				shadow_fill++;
		end else if (shadow_fill != 0) begin
			r.popped = shadow_mem[shadow_top];
			r.valid  = 1'b1;
			shadow_top = (shadow_top == 0) ? STACK_DEPTH - 1 : shadow_top - 1;
			shadow_fill--;
		end
		r.count = COUNT_W'(shadow_fill);
		return r;
	endfunction

	function automatic void field_check(input string name, input logic signed [63:0] want,
	                                    input logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Drive items: load the next one only once the current one has gone
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_fire)) begin
			if (pending_ops.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_op = pending_ops.pop_front();
				item_valid <= 1'b1;
				func       <= next_op.op;
				push_value <= next_op.value;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Drive result_ready: a requested hold wins over random idling
	always @(negedge clk) begin
		if (arst_n) begin
			if (holds_served != hold_requests) begin
				holds_served <= hold_requests;
				rx_hold_left <= RX_HOLD_CYCLES;
				result_ready <= 1'b0;
			end else if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Observe both channels; check results before predicting new ones
	always @(posedge clk) begin
		if (arst_n) begin
			item_fire <= item_valid && item_ready;
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual value %0d count %0d",
					         $time, popped_value, entry_count);
					mismatches++;
				end else begin
					want_result = awaited_results.pop_front();
					field_check("popped_value", want_result.popped, popped_value);
					field_check("pop_valid", want_result.valid, pop_valid);
					field_check("overwrote_oldest", want_result.overwrote, overwrote_oldest);
					field_check("entry_count", want_result.count, entry_count);
				end
			end
			if (item_valid && item_ready) begin
				seen_op.op    = func;
				seen_op.value = push_value;
				awaited_results.push_back(stack_apply(seen_op));
			end
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Abort when nothing moves for too long
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic queue_push(input logic signed [VALUE_W-1:0] v);
		stack_item_t it;
		it.op    = FUNC_PUSH;
		it.value = v;
		pending_ops.push_back(it);
	endtask

	task automatic queue_pop();
		stack_item_t it;
		it.op    = FUNC_POP;
		it.value = $urandom;
		pending_ops.push_back(it);
	endtask

	function automatic logic signed [VALUE_W-1:0] random_word();
		case ($urandom_range(11))
			0:       return '0;
			1:       return '1;
			2:       return {1'b1, {(VALUE_W-1){1'b0}}};
			3:       return {1'b0, {(VALUE_W-1){1'b1}}};
			default: return $urandom;
		endcase
	endfunction

	// Bursts of pushes and pops reach both full and empty; a few lone ops as noise
	task automatic queue_random_ops(input int n);
		int burst;
		int kind;
		while (n > 0) begin
			kind  = $urandom_range(19);
			burst = $urandom_range(20, 1);
			if (burst > n)
				burst = n;
			n -= burst;
			repeat (burst) begin
				if (kind < 9)
					queue_push(random_word());
				else if (kind < 18)
					queue_pop();
				else if ($urandom_range(1))
					queue_pop();
				else
					queue_push(random_word());
			end
		end
	endtask

	// Hold the sender until every owed result has come back
	task automatic drain();
		while (pending_ops.size() > 0 || item_valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pop, extremes, overflow with wrap, pops across the wrap
		tx_idle_pct = 13;
		rx_idle_pct = 73;
		queue_pop();
		queue_push({1'b0, {(VALUE_W-1){1'b1}}});
		queue_push({1'b1, {(VALUE_W-1){1'b0}}});
		queue_pop();
		queue_pop();
		queue_pop();
		queue_push('0);
		queue_push('1);
		queue_push(32'shAAAAAAAA);
		queue_push(32'sh55555555);
		for (int i = 0; i < STACK_DEPTH - 3; i++)
			queue_push($urandom);
		queue_pop();
		queue_pop();

		queue_random_ops(ITEMS_PER_PHASE / 2);
		drain();
		queue_random_ops(ITEMS_PER_PHASE / 2);
		drain();

		tx_idle_pct = 73;
		rx_idle_pct = 13;
		queue_random_ops(ITEMS_PER_PHASE);
		drain();

		// No idling; a long receiver hold backs the block up into its input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random_ops(ITEMS_PER_PHASE);
		hold_requests++;
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
